// ----- rtl/pst_pkg.sv -----
// Shared types and constants for the Pascal source tokenizer.
// No dependencies; used by every module in rtl/.
package pst_pkg;

	localparam int KIND_W = 5;
	localparam int ERR_W  = 3;
	localparam int OFF_W  = 32;
	localparam int LINE_W = 24;
	localparam int COL_W  = 16;
	localparam int LEN_W  = 16;
	localparam int MAX_TOK = 3;

	typedef enum logic [4:0] {
		M_IDLE, M_IDENT, M_INT, M_INTDOT, M_FRAC, M_EXP, M_EXPDIG, M_STR, M_STRQ,
		M_CODE, M_LT, M_GT, M_COLON, M_DOT, M_LPAR, M_SLASH, M_LINEC, M_BLOCKC
	} mode_t;

	typedef enum logic [1:0] {PC_NONE, PC_STAR, PC_LPAR} pc_t;

	localparam logic [KIND_W-1:0] K_END = 5'd0, K_IDENT = 5'd1, K_INT = 5'd2,
		K_REAL = 5'd3, K_STRING = 5'd4, K_CHAR = 5'd5, K_CODE = 5'd6, K_ASSIGN = 5'd7,
		K_LE = 5'd8, K_GE = 5'd9, K_NE = 5'd10, K_RANGE = 5'd11, K_PLUS = 5'd12,
		K_MINUS = 5'd13, K_STAR = 5'd14, K_SLASHOP = 5'd15, K_EQ = 5'd16,
		K_LTOP = 5'd17, K_GTOP = 5'd18, K_SEMI = 5'd19, K_COMMA = 5'd20,
		K_DOTOP = 5'd21, K_COLONOP = 5'd22, K_LPAROP = 5'd23, K_RPAR = 5'd24,
		K_LBRK = 5'd25, K_RBRK = 5'd26, K_CARET = 5'd27, K_AT = 5'd28, K_BAD = 5'd29;

	localparam logic [ERR_W-1:0] E_NONE = 3'd0, E_CHAR = 3'd1, E_STRING = 3'd2,
		E_CODE = 3'd3, E_COMMENT = 3'd4;

	localparam logic [LEN_W-1:0] LEN_TOP = 16'hFFFF;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_of_source;
	} src_t;

	typedef struct packed {
		logic [KIND_W-1:0] token_kind;
		logic [ERR_W-1:0]  error_code;
		logic [OFF_W-1:0]  start_offset;
		logic [LINE_W-1:0] start_line;
		logic [COL_W-1:0]  start_column;
		logic [LEN_W-1:0]  token_length;
		logic              last_of_run;
	} tok_t;

	// all tokens caused by one source beat
	typedef struct packed {
		logic [1:0]           cnt;
		tok_t [MAX_TOK-1:0]   tok;
	} bundle_t;

	function automatic logic [KIND_W-1:0] single_op(input logic [7:0] b);
		case (b)
			8'h2B: return K_PLUS;
			8'h2D: return K_MINUS;
			8'h2A: return K_STAR;
			8'h3D: return K_EQ;
			8'h3B: return K_SEMI;
			8'h2C: return K_COMMA;
			8'h29: return K_RPAR;
			8'h5B: return K_LBRK;
			8'h5D: return K_RBRK;
			8'h5E: return K_CARET;
			8'h40: return K_AT;
			default: return K_END;
		endcase
	endfunction

endpackage

// ----- rtl/pst_front.sv -----
// Front end: accepts source beats, runs the character scanner and position
// counters, and packs the tokens of each beat into one bundle. Uses pst_pkg.
module pst_front import pst_pkg::*; #(
	parameter int OFFSET_BITS = 32,
	parameter int LINE_BITS   = 24,
	parameter int COLUMN_BITS = 16,
	parameter int NEST_BITS   = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  src_t    src,
	output logic    push,
	output bundle_t bundle
);

	mode_t                  mode_q;
	pc_t                    pc_q;
	logic [OFFSET_BITS-1:0] off_q, so_q;
	logic [LINE_BITS-1:0]   line_q, sl_q;
	logic [COLUMN_BITS-1:0] col_q, sc_q;
	logic [LEN_W-1:0]       len_q;
	logic [1:0]             scc_q;
	logic [NEST_BITS-1:0]   dep_q;

	mode_t                  mode_d;
	pc_t                    pc_d;
	logic [OFFSET_BITS-1:0] so_d;
	logic [LINE_BITS-1:0]   sl_d;
	logic [COLUMN_BITS-1:0] sc_d;
	logic [LEN_W-1:0]       len_d;
	logic [1:0]             scc_d;
	logic [NEST_BITS-1:0]   dep_d;

	function automatic tok_t mk(input logic [KIND_W-1:0] k, input logic [ERR_W-1:0] e,
			input logic [OFFSET_BITS-1:0] o, input logic [LINE_BITS-1:0] l,
			input logic [COLUMN_BITS-1:0] c, input logic [LEN_W-1:0] n);
		tok_t t;
		t.token_kind   = k;
		t.error_code   = e;
		t.start_offset = OFF_W'(o);
		t.start_line   = LINE_W'(l);
		t.start_column = COL_W'(c);
		t.token_length = n;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	logic [7:0] b;
	logic       is_dig, is_let, is_ws;
	logic [7:0] low;

	always_comb begin
		b      = src.source_byte;
		low    = b | 8'h20;
		is_dig = (b >= 8'h30) && (b <= 8'h39);
		is_let = ((low >= 8'h61) && (low <= 8'h7A)) || (b == 8'h5F);
		is_ws  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
	end

	always_comb begin
		logic                  act, cons, bg, ea, eb;
		mode_t                 bm;
		logic [KIND_W-1:0]     ka, op;
		logic [ERR_W-1:0]      ee;
		tok_t                  tb;
		logic [1:0]            n;
		logic [COLUMN_BITS-1:0] rc;
		mode_d = mode_q; pc_d = pc_q; so_d = so_q; sl_d = sl_q; sc_d = sc_q;
		len_d = len_q; scc_d = scc_q; dep_d = dep_q;
		bundle = '0;
		n = 2'd0;
		ka = K_END; ee = E_NONE; ea = 1'b0;
		tb = '0; bm = M_IDLE; op = K_END; rc = '0;
		act = 1'b1; cons = 1'b0; bg = 1'b0; eb = 1'b0;
		if (src.end_of_source) begin
			ea = 1'b1;
			unique case (mode_q)
				M_IDENT: ka = K_IDENT;
				M_INT: ka = K_INT;
				M_INTDOT, M_FRAC, M_EXP, M_EXPDIG: ka = K_REAL;
				M_STR: begin ka = K_BAD; ee = E_STRING; end
				M_STRQ: ka = (scc_q == 2'd1) ? K_CHAR : K_STRING;
				M_CODE: begin
					ka = (len_q > 16'd1) ? K_CODE : K_BAD;
					ee = (len_q > 16'd1) ? E_NONE : E_CODE;
				end
				M_LT: ka = K_LTOP;
				M_GT: ka = K_GTOP;
				M_COLON: ka = K_COLONOP;
				M_DOT: ka = K_DOTOP;
				M_LPAR: ka = K_LPAROP;
				M_SLASH: ka = K_SLASHOP;
				M_BLOCKC: begin ka = K_BAD; ee = E_COMMENT; end
				default: ea = 1'b0;
			endcase
			if (ea) begin
				bundle.tok[n] = mk(ka, ee, so_q, sl_q, sc_q, len_q);
				n = n + 2'd1;
			end
			bundle.tok[n] = mk(K_END, E_NONE, off_q, line_q, col_q, '0);
			n = n + 2'd1;
			mode_d = M_IDLE; dep_d = '0; pc_d = PC_NONE;
		end else begin
			// a byte may close a pending token and then be scanned again
			for (int i = 0; i < 4; i++) begin
				if (act) begin
					cons = 1'b1; bg = 1'b0; ea = 1'b0; eb = 1'b0; ee = E_NONE; ka = K_END;
					unique case (mode_d)
						M_IDLE: begin
							if (is_ws) begin
							end else if (is_let) begin
								bg = 1'b1; bm = M_IDENT;
							end else if (is_dig) begin
								bg = 1'b1; bm = M_INT;
							end else begin
								bg = 1'b1;
								case (b)
									8'h27: bm = M_STR;
									8'h23: bm = M_CODE;
									8'h7B: begin
										bm = M_BLOCKC; dep_d = NEST_BITS'(1); pc_d = PC_NONE;
									end
									8'h28: bm = M_LPAR;
									8'h2F: bm = M_SLASH;
									8'h3A: bm = M_COLON;
									8'h3C: bm = M_LT;
									8'h3E: bm = M_GT;
									8'h2E: bm = M_DOT;
									default: begin
										bm = M_IDLE; ea = 1'b1;
										op = single_op(b);
										ka = (op != K_END) ? op : K_BAD;
										ee = (op != K_END) ? E_NONE : E_CHAR;
									end
								endcase
							end
						end
						M_IDENT: begin
							if (is_let || is_dig) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
							end else begin
								ea = 1'b1; ka = K_IDENT; cons = 1'b0;
							end
						end
						M_INT: begin
							if (is_dig) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
							end else if (b == 8'h2E) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
								mode_d = M_INTDOT;
							end else begin
								ea = 1'b1; ka = K_INT; cons = 1'b0;
							end
						end
						M_INTDOT: begin
							if (b == 8'h2E) begin
								// range: int ends before the first dot
								rc = (&col_q) ? col_q : col_q - COLUMN_BITS'(1);
								if (len_d != LEN_TOP) len_d = len_d - 16'd1;
								ea = 1'b1; ka = K_INT; eb = 1'b1;
								tb = mk(K_RANGE, E_NONE, off_q - OFFSET_BITS'(1), line_q, rc,
									16'd2);
							end else begin
								mode_d = M_FRAC; cons = 1'b0;
							end
						end
						M_FRAC: begin
							if (is_dig) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
							end else if (low == 8'h65) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
								mode_d = M_EXP;
							end else begin
								ea = 1'b1; ka = K_REAL; cons = 1'b0;
							end
						end
						M_EXP: begin
							if (b == 8'h2B || b == 8'h2D || is_dig) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
								mode_d = M_EXPDIG;
							end else begin
								ea = 1'b1; ka = K_REAL; cons = 1'b0;
							end
						end
						M_EXPDIG: begin
							if (is_dig) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
							end else begin
								ea = 1'b1; ka = K_REAL; cons = 1'b0;
							end
						end
						M_STR: begin
							if (b == 8'h0A) begin
								ea = 1'b1; ka = K_BAD; ee = E_STRING; cons = 1'b0;
							end else begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
								if (b == 8'h27) mode_d = M_STRQ;
								else if (scc_d != 2'd2) scc_d = scc_d + 2'd1;
							end
						end
						M_STRQ: begin
							if (b == 8'h27) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
								if (scc_d != 2'd2) scc_d = scc_d + 2'd1;
								mode_d = M_STR;
							end else begin
								ea = 1'b1; cons = 1'b0;
								ka = (scc_d == 2'd1) ? K_CHAR : K_STRING;
							end
						end
						M_CODE: begin
							if (is_dig) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
							end else begin
								ea = 1'b1; cons = 1'b0;
								ka = (len_d > 16'd1) ? K_CODE : K_BAD;
								ee = (len_d > 16'd1) ? E_NONE : E_CODE;
							end
						end
						M_LT: begin
							if (b == 8'h3D || b == 8'h3E) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
								ea = 1'b1; ka = (b == 8'h3D) ? K_LE : K_NE;
							end else begin
								ea = 1'b1; ka = K_LTOP; cons = 1'b0;
							end
						end
						M_GT: begin
							if (b == 8'h3D) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
								ea = 1'b1; ka = K_GE;
							end else begin
								ea = 1'b1; ka = K_GTOP; cons = 1'b0;
							end
						end
						M_COLON: begin
							if (b == 8'h3D) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
								ea = 1'b1; ka = K_ASSIGN;
							end else begin
								ea = 1'b1; ka = K_COLONOP; cons = 1'b0;
							end
						end
						M_DOT: begin
							if (b == 8'h2E) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
								ea = 1'b1; ka = K_RANGE;
							end else begin
								ea = 1'b1; ka = K_DOTOP; cons = 1'b0;
							end
						end
						M_LPAR: begin
							if (b == 8'h2A) begin
								if (len_d != LEN_TOP) len_d = len_d + 16'd1;
								mode_d = M_BLOCKC; dep_d = NEST_BITS'(1); pc_d = PC_NONE;
							end else begin
								ea = 1'b1; ka = K_LPAROP; cons = 1'b0;
							end
						end
						M_SLASH: begin
							if (b == 8'h2F) mode_d = M_LINEC;
							else begin
								ea = 1'b1; ka = K_SLASHOP; cons = 1'b0;
							end
						end
						M_LINEC: begin
							if (b == 8'h0A) begin
								mode_d = M_IDLE; cons = 1'b0;
							end
						end
						M_BLOCKC: begin
							if (len_d != LEN_TOP) len_d = len_d + 16'd1;
							if (pc_d == PC_STAR && b == 8'h29) begin
								if (dep_d != '0) dep_d = dep_d - NEST_BITS'(1);
								pc_d = PC_NONE;
							end else if (pc_d == PC_LPAR && b == 8'h2A) begin
								if (!(&dep_d)) dep_d = dep_d + NEST_BITS'(1);
								pc_d = PC_NONE;
							end else if (b == 8'h7D) begin
								if (dep_d != '0) dep_d = dep_d - NEST_BITS'(1);
								pc_d = PC_NONE;
							end else if (b == 8'h7B) begin
								if (!(&dep_d)) dep_d = dep_d + NEST_BITS'(1);
								pc_d = PC_NONE;
							end else if (b == 8'h2A) pc_d = PC_STAR;
							else if (b == 8'h28) pc_d = PC_LPAR;
							else pc_d = PC_NONE;
							if (dep_d == '0) mode_d = M_IDLE;
						end
						default: begin
							mode_d = M_IDLE; cons = 1'b0;
						end
					endcase
					if (bg) begin
						so_d = off_q; sl_d = line_q; sc_d = col_q;
						len_d = 16'd1; scc_d = 2'd0; mode_d = bm;
					end
					if (ea) begin
						bundle.tok[n] = mk(ka, ee, so_d, sl_d, sc_d, len_d);
						n = n + 2'd1;
						mode_d = M_IDLE;
					end
					if (eb) begin
						bundle.tok[n] = tb;
						n = n + 2'd1;
					end
					if (cons) act = 1'b0;
				end
			end
		end
		bundle.cnt = n;
		push = accept && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pc_q <= PC_NONE;
			off_q <= '0; line_q <= LINE_BITS'(1); col_q <= COLUMN_BITS'(1);
			so_q <= '0; sl_q <= LINE_BITS'(1); sc_q <= COLUMN_BITS'(1);
			len_q <= '0; scc_q <= '0; dep_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d; pc_q <= pc_d; so_q <= so_d; sl_q <= sl_d; sc_q <= sc_d;
			len_q <= len_d; scc_q <= scc_d; dep_q <= dep_d;
			if (!src.end_of_source) begin
				off_q <= off_q + OFFSET_BITS'(1);
				if (b == 8'h0A) begin
					if (!(&line_q)) line_q <= line_q + LINE_BITS'(1);
					col_q <= COLUMN_BITS'(1);
				end else if (!(&col_q)) begin
					col_q <= col_q + COLUMN_BITS'(1);
				end
			end
		end
	end

endmodule

// ----- rtl/pst_queue.sv -----
// Two-entry bundle queue between the scanner and the token serializer.
// Uses pst_pkg.
module pst_queue import pst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  bundle_t    wdata,
	input  logic       pop,
	output bundle_t    head,
	output logic       empty,
	output logic       full,
	output logic [1:0] level
);

	bundle_t    mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign head  = mem_q[rp_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- rtl/pst_back.sv -----
// Back end: walks the head bundle, one token per unstalled beat, into the
// output register and marks the last token of each bundle. Uses pst_pkg.
module pst_back import pst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  bundle_t head,
	input  logic    empty,
	output logic    pop,
	output logic    tok_valid,
	input  logic    tok_stall,
	output tok_t    tok
);

	logic [1:0] idx_q;
	logic       valid_q;
	tok_t       data_q;
	tok_t       nxt;
	logic       load, take, last;

	assign load      = !valid_q || !tok_stall;
	assign take      = load && !empty;
	assign last      = (idx_q == head.cnt - 2'd1);
	assign pop       = take && last;
	assign tok_valid = valid_q;
	assign tok       = data_q;

	always_comb begin
		nxt             = head.tok[idx_q];
		nxt.last_of_run = last;
	end

	always_ff @(posedge clk) begin
		if (take) data_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0; idx_q <= 2'd0;
		end else begin
			if (load) valid_q <= take;
			if (take) idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ----- rtl/pascal_source_tokenizer.sv -----
// Pascal source tokenizer: one source byte (or end marker) per beat on src,
// one token record per beat on tok; the last token of each source beat has
// last_of_run set. Takes one source beat per cycle while the two-bundle queue
// between scanner and serializer has room; the output side delivers one token
// per cycle while tok_stall is low, so a beat that yields two tokens holds the
// output for both. Tokens pass through the bundle queue, then the output register.
module pascal_source_tokenizer import pst_pkg::*; #(
	parameter int OFFSET_BITS = 32,
	parameter int LINE_BITS   = 24,
	parameter int COLUMN_BITS = 16,
	parameter int NEST_BITS   = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic src_valid,
	output logic src_stall,
	input  src_t src,
	output logic tok_valid,
	input  logic tok_stall,
	output tok_t tok
);

	logic       accept, push, pop, empty, full;
	logic [1:0] level;
	bundle_t    bundle, head;

	assign src_stall = full;
	assign accept    = src_valid && !full;

	pst_front #(
		.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS),
		.COLUMN_BITS(COLUMN_BITS), .NEST_BITS(NEST_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .src(src),
		.push(push), .bundle(bundle)
	);

	pst_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(bundle), .pop(pop),
		.head(head), .empty(empty), .full(full), .level(level)
	);

	pst_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .empty(empty), .pop(pop),
		.tok_valid(tok_valid), .tok_stall(tok_stall), .tok(tok)
	);

`ifndef NO_ASSERTIONS
	a_level_max: assert property (@(posedge clk) disable iff (!arst_n) level != 2'd3)
		else $error("queue level out of range");
	a_end_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src.end_of_source |=> level != 2'd0)
		else $error("end beat left no bundle");
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_stall && !tok.last_of_run |=> tok_valid)
		else $error("token run broken");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
`endif

endmodule

// ----- verif/pascal_source_tokenizer_tb.sv -----
// Testbench for pascal_source_tokenizer: streams source bytes and end markers,
// predicts token records in a local scanner model and checks every token beat.
// Depends on rtl/pst_pkg.sv and rtl/pascal_source_tokenizer.sv.
module pascal_source_tokenizer_tb;
	import pst_pkg::*;

	logic clk;
	logic arst_n;
	logic src_valid;
	logic src_stall;
	src_t src;
	logic tok_valid;
	logic tok_stall;
	tok_t tok;

	pascal_source_tokenizer dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src(src),
		.tok_valid(tok_valid), .tok_stall(tok_stall), .tok(tok)
	);

	localparam int CYCLE_LIMIT = 200000;

	// scanner state kept by the predictor
	mode_t            sc_mode;
	logic [OFF_W-1:0] sc_off;
	logic [LINE_W-1:0] sc_line;
	logic [COL_W-1:0] sc_col;
	logic [OFF_W-1:0] st_off;
	logic [LINE_W-1:0] st_line;
	logic [COL_W-1:0] st_col;
	logic [LEN_W-1:0] tk_len;
	logic [1:0]       str_cnt;
	logic [7:0]       nest;
	pc_t              prev_cb;

	tok_t expected_tokens[$];
	tok_t step_toks[$];
	int   failures;
	int   cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_dig(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_let(logic [7:0] b);
		logic [7:0] l;
		l = b | 8'h20;
		return (l >= "a" && l <= "z") || b == "_";
	endfunction

	function automatic logic [KIND_W-1:0] op_kind(logic [7:0] b);
		case (b)
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"=": return K_EQ;
			";": return K_SEMI;
			",": return K_COMMA;
			")": return K_RPAR;
			"[": return K_LBRK;
			"]": return K_RBRK;
			"^": return K_CARET;
			"@": return K_AT;
			default: return K_END;
		endcase
	endfunction

	task automatic push_tok(logic [KIND_W-1:0] k, logic [ERR_W-1:0] e, logic [OFF_W-1:0] o,
			logic [LINE_W-1:0] ln, logic [COL_W-1:0] c, logic [LEN_W-1:0] len);
		tok_t t;
		t.token_kind = k;
		t.error_code = e;
		t.start_offset = o;
		t.start_line = ln;
		t.start_column = c;
		t.token_length = len;
		t.last_of_run = 1'b0;
		step_toks = {step_toks, t};
	endtask

	task automatic close_tok(logic [KIND_W-1:0] k, logic [ERR_W-1:0] e);
		push_tok(k, e, st_off, st_line, st_col, tk_len);
		sc_mode = M_IDLE;
	endtask

	task automatic open_tok(mode_t m);
		st_off = sc_off;
		st_line = sc_line;
		st_col = sc_col;
		tk_len = LEN_W'(1);
		str_cnt = 2'd0;
		sc_mode = m;
	endtask

	function automatic void grow();
		if (tk_len != LEN_TOP) tk_len++;
	endfunction

	function automatic void nest_up();
		if (nest != 8'hFF) nest++;
	endfunction

	function automatic void nest_down();
		if (nest != 0) nest--;
	endfunction

	// one pass over byte b; returns 0 when the byte must be scanned again
	task automatic scan_byte(logic [7:0] b, output bit done);
		logic [KIND_W-1:0] k;
		logic [COL_W-1:0] c;
		done = 1;
		case (sc_mode)
			M_IDLE: begin
				if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A) return;
				if (is_let(b)) open_tok(M_IDENT);
				else if (is_dig(b)) open_tok(M_INT);
				else case (b)
					"'": open_tok(M_STR);
					"#": open_tok(M_CODE);
					"{": begin
						open_tok(M_BLOCKC);
						nest = 8'd1;
						prev_cb = PC_NONE;
					end
					"(": open_tok(M_LPAR);
					"/": open_tok(M_SLASH);
					":": open_tok(M_COLON);
					"<": open_tok(M_LT);
					">": open_tok(M_GT);
					".": open_tok(M_DOT);
					default: begin
						open_tok(M_IDLE);
						k = op_kind(b);
						if (k != K_END) close_tok(k, E_NONE);
						else close_tok(K_BAD, E_CHAR);
					end
				endcase
			end
			M_IDENT: if (is_let(b) || is_dig(b)) grow();
				else begin close_tok(K_IDENT, E_NONE); done = 0; end
			M_INT: if (is_dig(b)) grow();
				else if (b == ".") begin grow(); sc_mode = M_INTDOT; end
				else begin close_tok(K_INT, E_NONE); done = 0; end
			M_INTDOT: if (b == ".") begin
					c = (sc_col == '1) ? sc_col : sc_col - COL_W'(1);
					if (tk_len != LEN_TOP) tk_len--;
					close_tok(K_INT, E_NONE);
					push_tok(K_RANGE, E_NONE, sc_off - OFF_W'(1), sc_line, c, LEN_W'(2));
				end else begin sc_mode = M_FRAC; done = 0; end
			M_FRAC: if (is_dig(b)) grow();
				else if (b == "e" || b == "E") begin grow(); sc_mode = M_EXP; end
				else begin close_tok(K_REAL, E_NONE); done = 0; end
			M_EXP: if (b == "+" || b == "-" || is_dig(b)) begin grow(); sc_mode = M_EXPDIG; end
				else begin close_tok(K_REAL, E_NONE); done = 0; end
			M_EXPDIG: if (is_dig(b)) grow();
				else begin close_tok(K_REAL, E_NONE); done = 0; end
			M_STR: if (b == 8'h0A) begin close_tok(K_BAD, E_STRING); done = 0; end
				else begin
					grow();
					if (b == "'") sc_mode = M_STRQ;
					else if (str_cnt < 2) str_cnt++;
				end
			M_STRQ: if (b == "'") begin
					grow();
					if (str_cnt < 2) str_cnt++;
					sc_mode = M_STR;
				end else begin
					close_tok(str_cnt == 1 ? K_CHAR : K_STRING, E_NONE);
					done = 0;
				end
			M_CODE: if (is_dig(b)) grow();
				else begin
					if (tk_len > 1) close_tok(K_CODE, E_NONE);
					else close_tok(K_BAD, E_CODE);
					done = 0;
				end
			M_LT: if (b == "=") begin grow(); close_tok(K_LE, E_NONE); end
				else if (b == ">") begin grow(); close_tok(K_NE, E_NONE); end
				else begin close_tok(K_LTOP, E_NONE); done = 0; end
			M_GT: if (b == "=") begin grow(); close_tok(K_GE, E_NONE); end
				else begin close_tok(K_GTOP, E_NONE); done = 0; end
			M_COLON: if (b == "=") begin grow(); close_tok(K_ASSIGN, E_NONE); end
				else begin close_tok(K_COLONOP, E_NONE); done = 0; end
			M_DOT: if (b == ".") begin grow(); close_tok(K_RANGE, E_NONE); end
				else begin close_tok(K_DOTOP, E_NONE); done = 0; end
			M_LPAR: if (b == "*") begin
					grow();
					sc_mode = M_BLOCKC;
					nest = 8'd1;
					prev_cb = PC_NONE;
				end else begin close_tok(K_LPAROP, E_NONE); done = 0; end
			M_SLASH: if (b == "/") sc_mode = M_LINEC;
				else begin close_tok(K_SLASHOP, E_NONE); done = 0; end
			M_LINEC: if (b == 8'h0A) begin sc_mode = M_IDLE; done = 0; end
			M_BLOCKC: begin
				grow();
				if (prev_cb == PC_STAR && b == ")") begin nest_down(); prev_cb = PC_NONE; end
				else if (prev_cb == PC_LPAR && b == "*") begin nest_up(); prev_cb = PC_NONE; end
				else if (b == "}") begin nest_down(); prev_cb = PC_NONE; end
				else if (b == "{") begin nest_up(); prev_cb = PC_NONE; end
				else if (b == "*") prev_cb = PC_STAR;
				else if (b == "(") prev_cb = PC_LPAR;
				else prev_cb = PC_NONE;
				if (nest == 0) sc_mode = M_IDLE;
			end
			default: begin sc_mode = M_IDLE; done = 0; end
		endcase
	endtask

	task automatic flush_pending();
		case (sc_mode)
			M_IDENT: close_tok(K_IDENT, E_NONE);
			M_INT: close_tok(K_INT, E_NONE);
			M_INTDOT, M_FRAC, M_EXP, M_EXPDIG: close_tok(K_REAL, E_NONE);
			M_STR: close_tok(K_BAD, E_STRING);
			M_STRQ: close_tok(str_cnt == 1 ? K_CHAR : K_STRING, E_NONE);
			M_CODE: if (tk_len > 1) close_tok(K_CODE, E_NONE); else close_tok(K_BAD, E_CODE);
			M_LT: close_tok(K_LTOP, E_NONE);
			M_GT: close_tok(K_GTOP, E_NONE);
			M_COLON: close_tok(K_COLONOP, E_NONE);
			M_DOT: close_tok(K_DOTOP, E_NONE);
			M_LPAR: close_tok(K_LPAROP, E_NONE);
			M_SLASH: close_tok(K_SLASHOP, E_NONE);
			M_BLOCKC: close_tok(K_BAD, E_COMMENT);
			default: ;
		endcase
		sc_mode = M_IDLE;
		nest = 8'd0;
		prev_cb = PC_NONE;
	endtask

	task automatic predict_tokens(src_t s);
		bit done;
		tok_t t;
		step_toks.delete();
		if (s.end_of_source) begin
			flush_pending();
			push_tok(K_END, E_NONE, sc_off, sc_line, sc_col, '0);
		end else begin
			for (int i = 0; i < 4; i++) begin
				scan_byte(s.source_byte, done);
				if (done) break;
			end
			sc_off++;
			if (s.source_byte == 8'h0A) begin
				if (sc_line != '1) sc_line++;
				sc_col = COL_W'(1);
			end else if (sc_col != '1) sc_col++;
		end
		foreach (step_toks[i]) begin
			t = step_toks[i];
			t.last_of_run = (i == step_toks.size() - 1);
			expected_tokens = {expected_tokens, t};
		end
	endtask

	task automatic send_beat(logic [7:0] b, bit eos);
		src_t s;
		int   idle;
		idle = $urandom_range(0, 3);
		if (idle != 0) begin
			src_valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		s.source_byte = b;
		s.end_of_source = eos;
		src <= s;
		src_valid <= 1'b1;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		predict_tokens(s);
		@(negedge clk);
	endtask

	task automatic send_text(string txt);
		for (int i = 0; i < txt.len(); i++) send_beat(txt[i], 0);
	endtask

	task automatic send_end();
		send_beat(8'h00, 1);
	endtask

	// receiver stall pattern
	initial begin
		tok_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			int waits;
			waits = (cycles % 2000 > 1500) ? 0 : $urandom_range(0, 3);
			if (waits != 0) begin
				tok_stall <= 1'b1;
				repeat (waits) @(negedge clk);
			end
			tok_stall <= 1'b0;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && tok_valid && !tok_stall) begin
			if (expected_tokens.size() == 0) begin
				$error("token with none expected: kind %0d", tok.token_kind);
				failures++;
			end else begin
				tok_t e;
				e = expected_tokens.pop_front();
				if (tok.token_kind !== e.token_kind) begin
					$error("token_kind exp %0d got %0d", e.token_kind, tok.token_kind);
					failures++;
				end
				if (tok.error_code !== e.error_code) begin
					$error("error_code exp %0d got %0d", e.error_code, tok.error_code);
					failures++;
				end
				if (tok.start_offset !== e.start_offset) begin
					$error("start_offset exp %0d got %0d", e.start_offset, tok.start_offset);
					failures++;
				end
				if (tok.start_line !== e.start_line) begin
					$error("start_line exp %0d got %0d", e.start_line, tok.start_line);
					failures++;
				end
				if (tok.start_column !== e.start_column) begin
					$error("start_column exp %0d got %0d", e.start_column, tok.start_column);
					failures++;
				end
				if (tok.token_length !== e.token_length) begin
					$error("token_length exp %0d got %0d", e.token_length, tok.token_length);
					failures++;
				end
				if (tok.last_of_run !== e.last_of_run) begin
					$error("last_of_run exp %0d got %0d", e.last_of_run, tok.last_of_run);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_operators();
		send_text(":= <= >= <> .. + - * / = < > ; , . : ( ) [ ] ^ @");
		send_text("<");
		send_end();
	endtask

	task automatic test_numbers();
		send_text("0 9 12.5e+3 7.E 3. 1..2 4.x ");
		send_text("8.");
		send_end();
	endtask

	task automatic test_strings_and_codes();
		send_text("'a' '''' '' 'ab' 'x");
		send_beat(8'h0A, 0);
		send_text("#65 # _Id9 ");
		send_beat(8'hFF, 0);
		send_beat(8'h01, 0);
		send_text("'open");
		send_end();
	endtask

	task automatic test_comments();
		send_text("{ a (* b *) } x // line");
		send_beat(8'h0A, 0);
		send_text("(* { *) } y { unclosed (* ");
		send_end();
	endtask

	// fragments of legal source mixed with raw bytes
	task automatic test_random_source();
		string frags[16];
		int    j;
		frags = '{"begin ", "x:=1;", "a[3]<>b^", "'it''s'", "#13#10", "3.14e-2 ",
			"{c{n}}", "(*z*)", "1..9", "// r\n", "p(q,r)", "x>=y", "'c'", "2E5 ",
			"@v.f", "\n\t"};
		for (int n = 0; n < 45; ) begin
			if ($urandom_range(0, 9) < 7) begin
				j = $urandom_range(0, 15);
				send_text(frags[j]);
				n += frags[j].len();
			end else begin
				send_beat(8'($urandom_range(0, 255)), 0);
				n++;
			end
			if ($urandom_range(0, 30) == 0) send_end();
		end
		send_end();
	endtask

	initial begin
		arst_n = 1'b0;
		src_valid = 1'b0;
		src = '0;
		failures = 0;
		cycles = 0;
		sc_mode = M_IDLE;
		sc_off = '0;
		sc_line = LINE_W'(1);
		sc_col = COL_W'(1);
		st_off = '0;
		st_line = LINE_W'(1);
		st_col = COL_W'(1);
		tk_len = '0;
		str_cnt = 2'd0;
		nest = 8'd0;
		prev_cb = PC_NONE;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_operators();
		test_numbers();
		test_strings_and_codes();
		test_comments();
		test_random_source();
		src_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/pst_pkg.sv
rtl/pst_front.sv
rtl/pst_queue.sv
rtl/pst_back.sv
rtl/pascal_source_tokenizer.sv
verif/pascal_source_tokenizer_tb.sv
